@@ design/ring_neighbor_exclusion_arbiter_macros.svh @@
// Assertion macros for the ring neighbor-exclusion arbiter.
// Included by the top level; no other dependencies.
`ifndef RING_NEIGHBOR_EXCLUSION_ARBITER_MACROS_SVH
`define RING_NEIGHBOR_EXCLUSION_ARBITER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RNEA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define RNEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/rnea_pkg.sv @@
// Shared types and codes for the ring neighbor-exclusion arbiter.
// Used by rnea_cell and ring_neighbor_exclusion_arbiter; no dependencies.
`default_nettype none

package rnea_pkg;

	typedef logic [1:0] seat_st_t;

	localparam seat_st_t SEAT_THINKING = 2'd0;
	localparam seat_st_t SEAT_HUNGRY   = 2'd1;
	localparam seat_st_t SEAT_EATING   = 2'd2;

	localparam logic FUNC_REQ = 1'b0;
	localparam logic FUNC_REL = 1'b1;

	localparam logic REG_SEAT_COUNT = 1'b0;

	localparam logic [4:0] SEAT_COUNT_RST = 5'd5;

	typedef struct packed {
		logic req;
		logic rel;
		logic chk;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ design/ring_neighbor_exclusion_arbiter.sv @@
// Request: the grant beat appears the cycle after start.
// Release: release plus left check, then right check; up to two grant beats
// follow on consecutive cycles; when there are two, busy stays high through the first one.
// The row of seat cells and the single right-check step make up this sequence.
// Reset: all seats thinking, seat_count = 5, no beat pending. Results cannot be stalled.
`default_nettype none

module ring_neighbor_exclusion_arbiter #(
	parameter int MAX_SEATS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         start,
	output logic        busy,
	input  wire         func,
	input  wire  [3:0]  seat,
	output logic        grant_valid,
	output logic [3:0]  granted_seat,
	output logic        last_of_run
);
	import rnea_pkg::*;

	`include "ring_neighbor_exclusion_arbiter_macros.svh"

	localparam int SW = $clog2(MAX_SEATS);
	localparam int NW = $clog2(MAX_SEATS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RIGHT = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [4:0]          seat_count_q;
	logic [NW-1:0]       ring_n;
	logic [SW-1:0]       last_idx;
	logic [1:0]          state_q;
	logic [1:0]          state_d;
	logic                pend_left_q;
	logic                pend_left_d;
	logic [SW-1:0]       left_q;
	logic [SW-1:0]       right_q;
	logic                out_v_q;
	logic                out_v_d;
	logic [3:0]          out_seat_q;
	logic [3:0]          out_seat_d;
	logic                out_last_q;
	logic                out_last_d;

	logic                go;
	logic                in_range;
	logic                go_ok;
	logic [SW-1:0]       seat_idx;
	logic [SW-1:0]       left_idx;
	logic [SW-1:0]       right_idx;
	seat_st_t            st_sel;
	logic                req_ok;
	logic                rel_ok;
	logic                any_grant;
	logic                cfg_wr;

	seat_st_t            cell_st [MAX_SEATS];
	cell_ctl_t           ctl [MAX_SEATS];
	logic [MAX_SEATS-1:0] eating;
	logic [MAX_SEATS-1:0] eat_vis;
	logic [MAX_SEATS-1:0] left_eat;
	logic [MAX_SEATS-1:0] right_eat;
	logic [MAX_SEATS-1:0] grant_vec;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_SEAT_COUNT) ? 32'(seat_count_q) : 32'd0;

	always_comb begin
		if (seat_count_q < 5'd2) begin
			ring_n = NW'(2);
		end else if (int'(seat_count_q) > MAX_SEATS) begin
			ring_n = NW'(MAX_SEATS);
		end else begin
			ring_n = NW'(seat_count_q);
		end
	end

	assign last_idx = SW'(int'(ring_n) - 1);

	// command decode
	assign busy     = (state_q != ST_IDLE);
	assign go       = start && !busy;
	assign in_range = int'(seat) < int'(ring_n);
	assign go_ok    = go && in_range;
	assign seat_idx = SW'(seat);
	assign st_sel   = cell_st[seat_idx];
	assign req_ok   = go_ok && (func == FUNC_REQ);
	assign rel_ok   = go_ok && (func == FUNC_REL) && (st_sel == SEAT_EATING);
	assign left_idx = (seat_idx == '0) ? last_idx : SW'(int'(seat_idx) - 1);
	assign right_idx = (int'(seat) + 1 >= int'(ring_n)) ? '0 : SW'(int'(seat_idx) + 1);
	assign any_grant = |grant_vec;

	// row of seat cells
	for (genvar i = 0; i < MAX_SEATS; i++) begin : g_seat
		assign ctl[i].req = req_ok && (seat_idx == SW'(i));
		assign ctl[i].rel = rel_ok && (seat_idx == SW'(i));
		assign ctl[i].chk = (rel_ok && (left_idx == SW'(i))) ||
			((state_q == ST_RIGHT) && (right_q == SW'(i)));
		assign eat_vis[i] = eating[i] && !ctl[i].rel;

		if (i == 0) begin : g_left_wrap
			assign left_eat[i] = eat_vis[last_idx];
		end else begin : g_left
			assign left_eat[i] = eat_vis[i-1];
		end

		if (i == MAX_SEATS - 1) begin : g_right_wrap
			assign right_eat[i] = eat_vis[0];
		end else begin : g_right
			assign right_eat[i] = (i + 1 >= int'(ring_n)) ? eat_vis[0] : eat_vis[i+1];
		end

		rnea_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[i]),
			.left_eat  (left_eat[i]),
			.right_eat (right_eat[i]),
			.st        (cell_st[i]),
			.eating    (eating[i]),
			.grant     (grant_vec[i])
		);
	end

	// sequencer and result beats
	always_comb begin
		state_d     = state_q;
		pend_left_d = pend_left_q;
		out_v_d     = 1'b0;
		out_seat_d  = out_seat_q;
		out_last_d  = out_last_q;
		case (state_q)
			ST_IDLE: begin
				if (req_ok && any_grant) begin
					out_v_d    = 1'b1;
					out_seat_d = seat;
					out_last_d = 1'b1;
				end
				if (rel_ok) begin
					pend_left_d = any_grant;
					state_d     = ST_RIGHT;
				end
			end
			ST_RIGHT: begin
				state_d = ST_IDLE;
				if (pend_left_q) begin
					out_v_d    = 1'b1;
					out_seat_d = 4'(left_q);
					out_last_d = !any_grant;
					if (any_grant) begin
						state_d = ST_EMIT;
					end
				end else if (any_grant) begin
					out_v_d    = 1'b1;
					out_seat_d = 4'(right_q);
					out_last_d = 1'b1;
				end
			end
			ST_EMIT: begin
				out_v_d    = 1'b1;
				out_seat_d = 4'(right_q);
				out_last_d = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seat_count_q <= SEAT_COUNT_RST;
			state_q      <= ST_IDLE;
			pend_left_q  <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == REG_SEAT_COUNT)) begin
				seat_count_q <= pwdata[4:0];
			end
			state_q     <= state_d;
			pend_left_q <= pend_left_d;
			out_v_q     <= out_v_d;
		end
	end

	always_ff @(posedge clk) begin
		out_seat_q <= out_seat_d;
		out_last_q <= out_last_d;
		if (go) begin
			left_q  <= left_idx;
			right_q <= right_idx;
		end
	end

	assign grant_valid  = out_v_q;
	assign granted_seat = out_seat_q;
	assign last_of_run  = out_last_q;

	`RNEA_ASSERT_NOW(a_one_grant, clk, arst_n, 1'b1, $onehot0(grant_vec), "more than one seat granted in a cycle")
	`RNEA_ASSERT_NOW(a_emit_beat, clk, arst_n, state_q == ST_EMIT, grant_valid && !last_of_run, "second grant not preceded by first beat")
	`RNEA_ASSERT_NEXT(a_run_ends, clk, arst_n, grant_valid && !last_of_run, grant_valid && last_of_run, "run of grants not closed")

endmodule

`default_nettype wire

@@ design/rnea_cell.sv @@
// One seat of the ring: holds the seat state and trades eating flags with neighbors.
// Depends on rnea_pkg.
`default_nettype none

module rnea_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  rnea_pkg::cell_ctl_t  ctl,
	input  wire                  left_eat,
	input  wire                  right_eat,
	output rnea_pkg::seat_st_t   st,
	output logic                 eating,
	output logic                 grant
);
	import rnea_pkg::*;

	seat_st_t st_q;
	seat_st_t st_d;
	logic     may_eat;

	assign may_eat = !left_eat && !right_eat;

	always_comb begin
		st_d  = st_q;
		grant = 1'b0;
		case (st_q)
			SEAT_THINKING: begin
				if (ctl.req) begin
					if (may_eat) begin
						st_d  = SEAT_EATING;
						grant = 1'b1;
					end else begin
						st_d = SEAT_HUNGRY;
					end
				end
			end
			SEAT_HUNGRY: begin
				if (ctl.chk && may_eat) begin
					st_d  = SEAT_EATING;
					grant = 1'b1;
				end
			end
			SEAT_EATING: begin
				if (ctl.rel) begin
					st_d = SEAT_THINKING;
				end
			end
			default: begin
				st_d = st_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SEAT_THINKING;
		end else begin
			st_q <= st_d;
		end
	end

	assign st     = st_q;
	assign eating = (st_q == SEAT_EATING);

endmodule

`default_nettype wire

@@ tb/sv/rnea_grant_checker.sv @@
// Grant checker for ring_neighbor_exclusion_arbiter: follows seat states and seat_count
// from the accepted beats and register writes, predicts grants and compares each grant beat.
// Depends on rnea_pkg.
module rnea_grant_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	input  wire         pready,
	input  wire         start,
	input  wire         busy,
	input  wire         func,
	input  wire  [3:0]  seat,
	input  wire         grant_valid,
	input  wire  [3:0]  granted_seat,
	input  wire         last_of_run,
	output int          fail_count,
	output int          waiting,
	output int          beat_count,
	output int          grant_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import rnea_pkg::*;

	localparam int SEATS_MAX = 16;

	typedef struct packed {
		logic [3:0] seat;
		logic       last;
	} grant_t;

	seat_st_t   seat_phase [SEATS_MAX];
	logic [4:0] count_reg;
	grant_t     grants_due [$];
	int         mism   = 0;
	int         beats  = 0;
	int         grants = 0;

	assign fail_count  = mism;
	assign beat_count  = beats;
	assign grant_count = grants;

	function automatic int ring_len();
		if (count_reg < 5'd2) return 2;
		if (int'(count_reg) > SEATS_MAX) return SEATS_MAX;
		return int'(count_reg);
	endfunction

	function automatic int left_seat(int s, int n);
		return (s == 0) ? n - 1 : s - 1;
	endfunction

	function automatic int right_seat(int s, int n);
		return (s + 1 >= n) ? 0 : s + 1;
	endfunction

	function automatic bit to_eating(int s, int n);
		if (seat_phase[s] == SEAT_HUNGRY && seat_phase[left_seat(s, n)] != SEAT_EATING &&
				seat_phase[right_seat(s, n)] != SEAT_EATING) begin
			seat_phase[s] = SEAT_EATING;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic take_beat(input logic f, input logic [3:0] s);
		int     n;
		int     hits;
		grant_t pair [2];
		n    = ring_len();
		hits = 0;
		if (int'(s) >= n) return;
		if (f == FUNC_REQ) begin
			if (seat_phase[s] != SEAT_THINKING) return;
			seat_phase[s] = SEAT_HUNGRY;
			if (to_eating(int'(s), n)) grants_due.push_back('{seat: s, last: 1'b1});
			return;
		end
		if (seat_phase[s] != SEAT_EATING) return;
		seat_phase[s] = SEAT_THINKING;
		if (to_eating(left_seat(int'(s), n), n)) begin
			pair[hits] = '{seat: 4'(left_seat(int'(s), n)), last: 1'b0};
			hits++;
		end
		if (to_eating(right_seat(int'(s), n), n)) begin
			pair[hits] = '{seat: 4'(right_seat(int'(s), n)), last: 1'b0};
			hits++;
		end
		for (int i = 0; i < hits; i++) begin
			pair[i].last = (i == hits - 1);
			grants_due.push_back(pair[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		grant_t due;
		if (!arst_n) begin
			foreach (seat_phase[i]) seat_phase[i] = SEAT_THINKING;
			count_reg = SEAT_COUNT_RST;
			grants_due.delete();
			waiting <= 0;
		end else begin
			if (grant_valid) begin
				grants++;
				if (grants_due.size() == 0) begin
					$error("grant beat for seat %0d with no grant due", granted_seat);
					mism++;
				end else begin
					due = grants_due.pop_front();
					if (granted_seat !== due.seat) begin
						$error("granted_seat: expected %0d, actual %0d", due.seat, granted_seat);
						mism++;
					end
					if (last_of_run !== due.last) begin
						$error("last_of_run: expected %0d, actual %0d", due.last, last_of_run);
						mism++;
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr[2] == REG_SEAT_COUNT)
				count_reg = pwdata[4:0];
			if (start && !busy) begin
				beats++;
				take_beat(func, seat);
			end
			waiting <= grants_due.size();
		end
	end

endmodule

@@ tb/sv/ring_neighbor_exclusion_arbiter_tb.sv @@
// Testbench top for ring_neighbor_exclusion_arbiter: drives request/release beats, with random
// gaps outside steady phases, and seat_count writes; checking is done by rnea_grant_checker.
// Depends on rnea_pkg, rnea_grant_checker and the arbiter RTL.
module ring_neighbor_exclusion_arbiter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rnea_pkg::*;

	localparam int         QUIET_LIMIT     = 4000;
	localparam int         DRAIN_CYCLES    = 8;
	localparam int         PHASE_BEATS     = 100;
	localparam logic [2:0] ADDR_SEAT_COUNT = {REG_SEAT_COUNT, 2'b00};
	localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic        start   = 1'b0;
	logic        func    = FUNC_REQ;
	logic [3:0]  seat    = '0;
	wire  [31:0] prdata;
	wire         pready;
	wire         busy;
	wire         grant_valid;
	wire  [3:0]  granted_seat;
	wire         last_of_run;

	int          fail_count;
	int          waiting;
	int          beat_count;
	int          grant_count;
	int          quiet    = 0;
	int          ring_now = 5;
	bit          steady   = 1'b0;
	logic [15:0] diners;
	int          ring_plan [$] = '{16, 0, 31, 1, 17, 3, 9};

	ring_neighbor_exclusion_arbiter #(.MAX_SEATS(16)) u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .func(func), .seat(seat),
		.grant_valid(grant_valid), .granted_seat(granted_seat), .last_of_run(last_of_run)
	);

	rnea_grant_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.start(start), .busy(busy), .func(func), .seat(seat),
		.grant_valid(grant_valid), .granted_seat(granted_seat), .last_of_run(last_of_run),
		.fail_count(fail_count), .waiting(waiting),
		.beat_count(beat_count), .grant_count(grant_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin : track_diners
		logic [15:0] nxt;
		if (!arst_n) begin
			diners <= '0;
		end else begin
			nxt = diners;
			if (start && !busy && func == FUNC_REL) nxt[seat] = 1'b0;
			if (grant_valid) nxt[granted_seat] = 1'b1;
			diners <= nxt;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || grant_valid || (psel && penable && pwrite && pready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: %0d cycles without a beat", QUIET_LIMIT);
			$display("ring_neighbor_exclusion_arbiter_tb failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic int ring_of(int v);
		if (v < 2) return 2;
		if (v > 16) return 16;
		return v;
	endfunction

	task automatic idle_gap();
		int n;
		n = gap_len();
		if (n > 0) begin
			start <= 1'b0;
			func  <= $urandom_range(1) ? FUNC_REL : FUNC_REQ;
			seat  <= 4'($urandom_range(15));
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_beat(input logic f, input logic [3:0] s);
		start <= 1'b1;
		func  <= f;
		seat  <= s;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		if (!steady) idle_gap();
	endtask

	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (waiting != 0 || busy) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_ring(input logic [2:0] addr, input int v);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {27'($urandom), 5'(v)};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_SEAT_COUNT) ring_now = ring_of(v);
	endtask

	task automatic pick_beat(output logic f, output logic [3:0] s);
		logic [15:0] live;
		int          r;
		r    = $urandom_range(99);
		f    = $urandom_range(1) ? FUNC_REL : FUNC_REQ;
		s    = 4'($urandom_range(ring_now - 1));
		live = diners & 16'((32'd1 << ring_now) - 1);
		if (r < 8) begin
			s = 4'($urandom_range(15));
		end else if (f == FUNC_REL && live != '0 && r < 80) begin
			while (!live[s]) s = 4'($urandom_range(ring_now - 1));
		end
	endtask

	initial begin
		logic       f;
		logic [3:0] s;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(FUNC_REQ, 4'd0);
		send_beat(FUNC_REQ, 4'd1);
		send_beat(FUNC_REQ, 4'd4);
		send_beat(FUNC_REQ, 4'd0);
		send_beat(FUNC_REL, 4'd3);
		send_beat(FUNC_REQ, 4'd15);
		send_beat(FUNC_REL, 4'd0);
		send_beat(FUNC_REQ, 4'd2);
		send_beat(FUNC_REQ, 4'd3);
		send_beat(FUNC_REL, 4'd1);
		send_beat(FUNC_REL, 4'd4);
		send_beat(FUNC_REL, 4'd2);
		send_beat(FUNC_REL, 4'd3);
		set_ring(ADDR_SEAT_COUNT, 2);
		send_beat(FUNC_REQ, 4'd0);
		send_beat(FUNC_REQ, 4'd1);
		send_beat(FUNC_REL, 4'd0);
		send_beat(FUNC_REL, 4'd1);
		send_beat(FUNC_REL, 4'd0);
		set_ring(ADDR_SEAT_COUNT, 16);
		send_beat(FUNC_REQ, 4'd15);
		send_beat(FUNC_REQ, 4'd0);
		send_beat(FUNC_REQ, 4'd14);
		send_beat(FUNC_REL, 4'd15);
		send_beat(FUNC_REL, 4'd14);
		send_beat(FUNC_REL, 4'd0);

		ring_plan.push_back($urandom_range(31));
		foreach (ring_plan[p]) begin
			set_ring(ADDR_SEAT_COUNT, ring_plan[p]);
			if (p == 0) set_ring(ADDR_UNMAPPED, 3);
			steady = (p % 3 == 2);
			repeat (PHASE_BEATS) begin
				pick_beat(f, s);
				send_beat(f, s);
			end
		end
		steady = 1'b0;
		settle();

		$display("covered %0d request/release beats across %0d seat_count settings",
			beat_count, ring_plan.size() + 2);
		$display("checked %0d grant beats, %0d mismatches", grant_count, fail_count);
		if (fail_count == 0) begin
			$display("ring_neighbor_exclusion_arbiter_tb passed");
		end else begin
			$display("ring_neighbor_exclusion_arbiter_tb failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/rnea_pkg.sv
design/rnea_cell.sv
design/ring_neighbor_exclusion_arbiter.sv
tb/sv/rnea_grant_checker.sv
tb/sv/ring_neighbor_exclusion_arbiter_tb.sv
